// ----- src/vpcs_pkg.sv -----
// Shared types, constants and arithmetic helpers for the video plane checksum block.
`timescale 1ns / 1ps
`default_nettype none

package vpcs_pkg;

    localparam int PLANES  = 4;
    localparam int PLANE_W = 2;

    localparam logic [16:0] ADLER_MOD       = 17'd65521;
    localparam logic [28:0] MAX_PLANE_BYTES = 29'd16777216;

    localparam int SUM_W = 32;
    localparam int SQ_W  = 40;
    localparam int CNT_W = 25;
    localparam int CFG_W = 3;

    // One plane's stored accumulators
    typedef struct packed {
        logic [31:0]      adler;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [CNT_W-1:0] cnt;
    } plane_entry_t;

    // Write port of the state memory
    typedef struct packed {
        logic               en;
        logic [PLANE_W-1:0] addr;
        plane_entry_t       data;
    } ram_wr_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_READ,
        ST_START,
        ST_WAIT,
        ST_LOAD
    } state_t;

    function automatic logic [31:0] adler_step(input logic [31:0] acc, input logic [7:0] b);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, acc[15:0]};
        s2 = {1'b0, acc[31:16]};
        if (s1 >= ADLER_MOD) s1 = s1 - ADLER_MOD;
        if (s2 >= ADLER_MOD) s2 = s2 - ADLER_MOD;
        s1 = s1 + {9'd0, b};
        if (s1 >= ADLER_MOD) s1 = s1 - ADLER_MOD;
        s2 = s2 + s1;
        if (s2 >= ADLER_MOD) s2 = s2 - ADLER_MOD;
        return {s2[15:0], s1[15:0]};
    endfunction

    function automatic plane_entry_t plane_update(input plane_entry_t e, input logic [7:0] b);
        plane_entry_t     r;
        logic [SUM_W:0]   sum_w;
        logic [SQ_W:0]    sq_w;
        logic [CNT_W:0]   cnt_w;
        logic [15:0]      b_sq;
        r       = e;
        r.adler = adler_step(e.adler, b);
        b_sq    = {8'd0, b} * {8'd0, b};
        if ({4'd0, e.cnt} < MAX_PLANE_BYTES) begin
            sum_w = {1'b0, e.sum} + {25'd0, b};
            sq_w  = {1'b0, e.sq} + {25'd0, b_sq};
            cnt_w = {1'b0, e.cnt} + 26'd1;
            r.sum = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
            r.sq  = sq_w[SQ_W] ? '1 : sq_w[SQ_W-1:0];
            r.cnt = cnt_w[CNT_W] ? '1 : cnt_w[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/vpcs_state_ram.sv -----
// Per-plane accumulator memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module vpcs_state_ram (
    input  wire                          clk,
    input  vpcs_pkg::ram_wr_t            wr,
    input  wire                          rd_en,
    input  wire [vpcs_pkg::PLANE_W-1:0]  rd_addr,
    output vpcs_pkg::plane_entry_t       rd_data
);

    vpcs_pkg::plane_entry_t mem_reg [vpcs_pkg::PLANES];
    vpcs_pkg::plane_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/vpcs_mean_div.sv -----
// Rounded, saturating mean divider: one restoring step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module vpcs_mean_div (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire [vpcs_pkg::SUM_W-1:0]   sum,
    input  wire [vpcs_pkg::CNT_W-1:0]   cnt,
    output logic                        done,
    output logic [7:0]                  mean
);

    logic [32:0] rem_reg;
    logic [32:0] div_reg;
    logic [8:0]  q_reg;
    logic [3:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        zero_reg;
    logic        ge;

    assign ge = rem_reg >= div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 4'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd8)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Top quotient bit set means the mean is at least 256: saturate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, sum} + {9'd0, cnt[vpcs_pkg::CNT_W-1:1]};
            div_reg  <= {cnt, 8'd0};
            q_reg    <= 9'd0;
            zero_reg <= (cnt == '0);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - div_reg;
            end
            q_reg   <= {q_reg[7:0], ge};
            div_reg <= {1'b0, div_reg[32:1]};
        end
    end

    assign done = done_reg;
    assign mean = zero_reg ? 8'd0 : (q_reg[8] ? 8'd255 : q_reg[7:0]);

endmodule

`default_nettype wire

// ----- src/video_plane_checksum_stats.sv -----
// Top level of the video plane checksum and statistics block.
`timescale 1ns / 1ps
`default_nettype none

// Streams the active bytes of a frame, each tagged with its plane, and keeps
// per plane a zero-based Adler-32, a saturating byte sum, sum of squares and
// byte count, plus one Adler-32 over the whole frame. Per-plane state lives
// in a four-entry memory with a registered read: a byte is read in the cycle
// it is accepted and updated and written back in the next, with the last
// written entry forwarded so bytes of the same plane can follow back to back.
// Streaming rate is one byte per cycle while in_stall is low. The byte
// marked frame_end closes the frame: input is stalled while one result per
// configured plane (plane 0 upward, last_result on the final one) is
// produced, each taking a memory read plus a nine-step serial divide for
// the rounded mean, plus any output stall. Then all state is cleared at
// once through per-entry valid bits and input resumes. plane_count must be
// written through the cfg channel only while no frame is in progress; the
// block does not enforce this. 0 reports one plane and values above four
// report four. cfg_ready drops during the result phase.
module video_plane_checksum_stats (
    input  wire                             clk,
    input  wire                             rst_n,
    // input byte transactions
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire  [7:0]                      sample,
    input  wire  [vpcs_pkg::PLANE_W-1:0]    plane,
    input  wire                             frame_end,
    // configuration write
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [vpcs_pkg::CFG_W-1:0]      plane_count,
    // result transactions
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [vpcs_pkg::PLANE_W-1:0]    plane_index,
    output logic [31:0]                     plane_adler32,
    output logic [31:0]                     frame_checksum,
    output logic [vpcs_pkg::SUM_W-1:0]      byte_sum,
    output logic [vpcs_pkg::SQ_W-1:0]       square_sum,
    output logic [vpcs_pkg::CNT_W-1:0]      byte_count,
    output logic [7:0]                      mean_value,
    output logic                            last_result
);

    vpcs_pkg::state_t state_reg;
    vpcs_pkg::state_t state_next;

    logic [vpcs_pkg::CFG_W-1:0]   plane_count_reg;
    logic [vpcs_pkg::CFG_W-1:0]   n_eff;

    // update stage
    logic                         s1_valid_reg;
    logic [7:0]                   s1_sample_reg;
    logic [vpcs_pkg::PLANE_W-1:0] s1_plane_reg;
    logic                         s1_end_reg;
    logic                         s1_hit_reg;
    logic                         fwd_hit_reg;
    vpcs_pkg::plane_entry_t       fwd_data_reg;

    logic [vpcs_pkg::PLANES-1:0]  entry_valid_reg;
    logic [31:0]                  frame_adler_reg;
    logic [vpcs_pkg::PLANE_W-1:0] k_reg;
    logic                         rep_hit_reg;

    // output register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [vpcs_pkg::PLANE_W-1:0] plane_index_reg;
    logic [31:0]                  plane_adler32_reg;
    logic [31:0]                  frame_checksum_reg;
    logic [vpcs_pkg::SUM_W-1:0]   byte_sum_reg;
    logic [vpcs_pkg::SQ_W-1:0]    square_sum_reg;
    logic [vpcs_pkg::CNT_W-1:0]   byte_count_reg;
    logic [7:0]                   mean_value_reg;
    logic                         last_result_reg;

    logic                         accept;
    logic                         rd_en;
    logic [vpcs_pkg::PLANE_W-1:0] rd_addr;
    vpcs_pkg::plane_entry_t       rd_data;
    vpcs_pkg::ram_wr_t            wr;
    vpcs_pkg::plane_entry_t       old_entry;
    vpcs_pkg::plane_entry_t       rep_entry;
    logic                         div_start;
    logic                         div_done;
    logic [7:0]                   div_mean;
    logic                         load;
    logic                         last_plane;
    logic                         frame_done;

    // Hold input off once the closing byte is in flight and during results
    assign in_stall  = (state_reg != vpcs_pkg::ST_RUN) || (s1_valid_reg && s1_end_reg);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = (state_reg == vpcs_pkg::ST_RUN);

    assign n_eff = (plane_count_reg == '0) ? vpcs_pkg::CFG_W'(1) :
                   ((plane_count_reg > vpcs_pkg::CFG_W'(vpcs_pkg::PLANES)) ?
                    vpcs_pkg::CFG_W'(vpcs_pkg::PLANES) : plane_count_reg);
    assign last_plane = ({1'b0, k_reg} + vpcs_pkg::CFG_W'(1)) == n_eff;
    assign frame_done = load && last_plane;

    assign rd_en   = accept || (state_reg == vpcs_pkg::ST_READ);
    assign rd_addr = (state_reg == vpcs_pkg::ST_RUN) ? plane : k_reg;

    // Forward the entry written at the same edge the read was taken
    assign old_entry = fwd_hit_reg ? fwd_data_reg : (s1_hit_reg ? rd_data : '0);
    assign rep_entry = rep_hit_reg ? rd_data : '0;

    always_comb
    begin
        wr.en   = s1_valid_reg &&
                  ({1'b0, s1_plane_reg} < (vpcs_pkg::PLANE_W + 1)'(vpcs_pkg::PLANES));
        wr.addr = s1_plane_reg;
        wr.data = vpcs_pkg::plane_update(old_entry, s1_sample_reg);
    end

    vpcs_state_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vpcs_mean_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (rep_entry.sum),
        .cnt   (rep_entry.cnt),
        .done  (div_done),
        .mean  (div_mean)
    );

    // Result sequencer
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        load       = 1'b0;
        case (state_reg)
            vpcs_pkg::ST_RUN:
            begin
                if (s1_valid_reg && s1_end_reg)
                begin
                    state_next = vpcs_pkg::ST_READ;
                end
            end
            vpcs_pkg::ST_READ:
            begin
                state_next = vpcs_pkg::ST_START;
            end
            vpcs_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = vpcs_pkg::ST_WAIT;
            end
            vpcs_pkg::ST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = vpcs_pkg::ST_LOAD;
                end
            end
            vpcs_pkg::ST_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load       = 1'b1;
                    state_next = last_plane ? vpcs_pkg::ST_RUN : vpcs_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = vpcs_pkg::ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= vpcs_pkg::ST_RUN;
            plane_count_reg <= vpcs_pkg::CFG_W'(1);
            s1_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            entry_valid_reg <= '0;
            frame_adler_reg <= 32'd0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= accept;
            fwd_hit_reg   <= accept && wr.en && (wr.addr == plane);
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                plane_count_reg <= plane_count;
            end
            if (s1_valid_reg)
            begin
                frame_adler_reg <= vpcs_pkg::adler_step(frame_adler_reg, s1_sample_reg);
            end
            if (wr.en)
            begin
                entry_valid_reg[wr.addr] <= 1'b1;
            end
            // Drop all accumulated state once the final result is loaded
            if (frame_done)
            begin
                entry_valid_reg <= '0;
                frame_adler_reg <= 32'd0;
            end
            if (state_reg == vpcs_pkg::ST_RUN)
            begin
                k_reg <= '0;
            end
            else if (load && !last_plane)
            begin
                k_reg <= k_reg + vpcs_pkg::PLANE_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_plane_reg  <= plane;
            s1_end_reg    <= frame_end;
            s1_hit_reg    <= entry_valid_reg[plane];
        end
        if (wr.en)
        begin
            fwd_data_reg <= wr.data;
        end
        if (state_reg == vpcs_pkg::ST_READ)
        begin
            rep_hit_reg <= entry_valid_reg[k_reg];
        end
        if (load)
        begin
            plane_index_reg    <= k_reg;
            plane_adler32_reg  <= rep_entry.adler;
            frame_checksum_reg <= frame_adler_reg;
            byte_sum_reg       <= rep_entry.sum;
            square_sum_reg     <= rep_entry.sq;
            byte_count_reg     <= rep_entry.cnt;
            mean_value_reg     <= div_mean;
            last_result_reg    <= last_plane;
        end
    end

    assign out_valid      = out_valid_reg;
    assign plane_index    = plane_index_reg;
    assign plane_adler32  = plane_adler32_reg;
    assign frame_checksum = frame_checksum_reg;
    assign byte_sum       = byte_sum_reg;
    assign square_sum     = square_sum_reg;
    assign byte_count     = byte_count_reg;
    assign mean_value     = mean_value_reg;
    assign last_result    = last_result_reg;

endmodule

`default_nettype wire

// ----- src/vpcs_checker.sv -----
// Port-level checker for the video plane checksum block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module vpcs_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             in_valid,
    input wire                             in_stall,
    input wire                             frame_end,
    input wire                             out_valid,
    input wire                             out_stall,
    input wire [vpcs_pkg::PLANE_W-1:0]     plane_index,
    input wire [31:0]                      plane_adler32,
    input wire [31:0]                      frame_checksum,
    input wire [vpcs_pkg::SUM_W-1:0]       byte_sum,
    input wire [vpcs_pkg::SQ_W-1:0]        square_sum,
    input wire [vpcs_pkg::CNT_W-1:0]       byte_count,
    input wire [7:0]                       mean_value,
    input wire                             last_result
);

    // A stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(plane_index) &&
        $stable(plane_adler32) && $stable(frame_checksum) && $stable(byte_sum) &&
        $stable(square_sum) && $stable(byte_count) && $stable(mean_value) &&
        $stable(last_result))
    else $error("result changed while stalled");

    // Accepting the closing byte raises in_stall
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && frame_end |=> in_stall)
    else $error("input accepted right after frame end");

    // An empty plane reports all zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_count == '0) |-> (byte_sum == '0) && (square_sum == '0) &&
        (plane_adler32 == 32'd0) && (mean_value == 8'd0))
    else $error("empty plane with nonzero statistics");

    // Nothing follows the final result of a frame directly
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_result |=> !out_valid)
    else $error("result after last result of frame");

endmodule

bind video_plane_checksum_stats vpcs_checker u_vpcs_checker (.*);

`default_nettype wire

// ----- bench/video_plane_checksum_stats_tb.sv -----
// Self-checking testbench for the video plane checksum and statistics block.
`timescale 1ns / 1ps

module video_plane_checksum_stats_tb;

    localparam int          CYCLE_LIMIT   = 200000;
    // settle time after the last report of a frame: state clear plus margin
    localparam int          SETTLE_CYCLES = 32;
    localparam int unsigned ADLER_BASE    = 65521;
    localparam longint unsigned BYTE_LIMIT = 64'd16777216;
    localparam longint unsigned SUM_TOP    = 64'hFFFF_FFFF;
    localparam longint unsigned SQ_TOP     = 64'hFF_FFFF_FFFF;
    localparam longint unsigned CNT_TOP    = 64'h1FF_FFFF;

    // One per-plane report as it leaves the block
    typedef struct packed {
        logic [vpcs_pkg::PLANE_W-1:0] plane_no;
        logic [31:0]                  plane_ck;
        logic [31:0]                  frame_ck;
        logic [vpcs_pkg::SUM_W-1:0]   sum;
        logic [vpcs_pkg::SQ_W-1:0]    sq;
        logic [vpcs_pkg::CNT_W-1:0]   cnt;
        logic [7:0]                   mean;
        logic                         last;
    } plane_report_t;

    // Predicts the per-plane reports of each frame and checks them in order.
    class plane_stats_board;
        logic [31:0]     plane_ck [vpcs_pkg::PLANES];
        logic [31:0]     frame_ck;
        longint unsigned sum_acc [vpcs_pkg::PLANES];
        longint unsigned sq_acc [vpcs_pkg::PLANES];
        longint unsigned cnt_acc [vpcs_pkg::PLANES];
        logic [vpcs_pkg::CFG_W-1:0] planes_reported;
        plane_report_t   report_q [$];
        int              mismatches;

        function new();
            clear_frame();
            planes_reported = 3'd1;
            mismatches = 0;
        endfunction

        function void clear_frame();
            for (int k = 0; k < vpcs_pkg::PLANES; k++)
            begin
                plane_ck[k] = '0;
                sum_acc[k]  = 0;
                sq_acc[k]   = 0;
                cnt_acc[k]  = 0;
            end
            frame_ck = '0;
        endfunction

        function void set_plane_count(logic [vpcs_pkg::CFG_W-1:0] value);
            planes_reported = value;
        endfunction

        // Zero-based Adler-32 advance; both halves stay below the modulus.
        function logic [31:0] adler_next(logic [31:0] acc, logic [7:0] b);
            int unsigned lo;
            int unsigned hi;
            lo = (int'(acc[15:0]) + int'(b)) % ADLER_BASE;
            hi = (int'(acc[31:16]) + lo) % ADLER_BASE;
            return {hi[15:0], lo[15:0]};
        endfunction

        function longint unsigned add_clamped(longint unsigned a, longint unsigned b,
                                              longint unsigned top);
            longint unsigned r;
            r = a + b;
            return (r > top) ? top : r;
        endfunction

        // Account one accepted byte; a frame end queues one report per configured plane.
        function void note_byte(logic [7:0] b, logic [vpcs_pkg::PLANE_W-1:0] p,
                                logic closes);
            int              n;
            longint unsigned m;
            plane_report_t   r;
            frame_ck = adler_next(frame_ck, b);
            plane_ck[p] = adler_next(plane_ck[p], b);
            if (cnt_acc[p] < BYTE_LIMIT)
            begin
                sum_acc[p] = add_clamped(sum_acc[p], 64'(b), SUM_TOP);
                sq_acc[p]  = add_clamped(sq_acc[p], 64'(b) * 64'(b), SQ_TOP);
                cnt_acc[p] = add_clamped(cnt_acc[p], 64'd1, CNT_TOP);
            end
            if (!closes)
                return;
            n = int'(planes_reported);
            if (n < 1)
                n = 1;
            if (n > vpcs_pkg::PLANES)
                n = vpcs_pkg::PLANES;
            for (int k = 0; k < n; k++)
            begin
                m = 0;
                if (cnt_acc[k] != 0)
                begin
                    m = (sum_acc[k] + cnt_acc[k] / 2) / cnt_acc[k];
                    if (m > 255)
                        m = 255;
                end
                r.plane_no = k[vpcs_pkg::PLANE_W-1:0];
                r.plane_ck = plane_ck[k];
                r.frame_ck = frame_ck;
                r.sum      = sum_acc[k][vpcs_pkg::SUM_W-1:0];
                r.sq       = sq_acc[k][vpcs_pkg::SQ_W-1:0];
                r.cnt      = cnt_acc[k][vpcs_pkg::CNT_W-1:0];
                r.mean     = m[7:0];
                r.last     = (k == n - 1);
                report_q.push_back(r);
            end
            clear_frame();
        endfunction

        function int pending();
            return report_q.size();
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (seen !== want)
            begin
                mismatches++;
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
            end
        endfunction

        function void check_report(plane_report_t got);
            plane_report_t want;
            if (report_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected report for plane %0d, expected none, got 0x%0h",
                         $time, got.plane_no, got);
                return;
            end
            want = report_q.pop_front();
            compare_field("plane_index", 64'(want.plane_no), 64'(got.plane_no));
            compare_field("plane_adler32", 64'(want.plane_ck), 64'(got.plane_ck));
            compare_field("frame_checksum", 64'(want.frame_ck), 64'(got.frame_ck));
            compare_field("byte_sum", 64'(want.sum), 64'(got.sum));
            compare_field("square_sum", 64'(want.sq), 64'(got.sq));
            compare_field("byte_count", 64'(want.cnt), 64'(got.cnt));
            compare_field("mean_value", 64'(want.mean), 64'(got.mean));
            compare_field("last_result", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n = 1'b0;

    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [7:0]                     sample = '0;
    logic [vpcs_pkg::PLANE_W-1:0]   plane = '0;
    logic                           frame_end = 1'b0;

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [vpcs_pkg::CFG_W-1:0]     plane_count = '0;

    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [vpcs_pkg::PLANE_W-1:0]   plane_index;
    logic [31:0]                    plane_adler32;
    logic [31:0]                    frame_checksum;
    logic [vpcs_pkg::SUM_W-1:0]     byte_sum;
    logic [vpcs_pkg::SQ_W-1:0]      square_sum;
    logic [vpcs_pkg::CNT_W-1:0]     byte_count;
    logic [7:0]                     mean_value;
    logic                           last_result;

    // Sender pacing: bursts of random length, with random gaps bounded by gap_max
    int                   burst_left = 0;
    int                   gap_max = 0;
    // Raised once to make the receiver hold off for a long stretch
    logic                 hold_request = 1'b0;
    int                   cycle_count = 0;

    plane_stats_board     board = new();

    video_plane_checksum_stats dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .plane          (plane),
        .frame_end      (frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .plane_count    (plane_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .plane_index    (plane_index),
        .plane_adler32  (plane_adler32),
        .frame_checksum (frame_checksum),
        .byte_sum       (byte_sum),
        .square_sum     (square_sum),
        .byte_count     (byte_count),
        .mean_value     (mean_value),
        .last_result    (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d reports outstanding",
                     $time, cycle_count, board.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: check each accepted report, then pick the next stall value.
    // The stall pattern cycles through segments of its own: no stall, heavy
    // random stall, a fixed two-of-three pattern and light random stall. A
    // single long hold-off overrides the pattern when the stimulus asks.
    int   rx_cycle = 0;
    int   hold_left = 0;
    logic hold_taken = 1'b0;

    always @(posedge clk)
    begin
        plane_report_t got;
        logic          stall_next;
        if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            got.plane_no = plane_index;
            got.plane_ck = plane_adler32;
            got.frame_ck = frame_checksum;
            got.sum      = byte_sum;
            got.sq       = square_sum;
            got.cnt      = byte_count;
            got.mean     = mean_value;
            got.last     = last_result;
            board.check_report(got);
        end
        if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = 150;
        end
        case ((rx_cycle / 150) % 4)
            0:       stall_next = 1'b0;
            1:       stall_next = ($urandom_range(0, 99) < 50);
            2:       stall_next = (rx_cycle % 3 != 0);
            default: stall_next = ($urandom_range(0, 99) < 20);
        endcase
        if (hold_left > 0)
        begin
            stall_next = 1'b1;
            hold_left--;
        end
        rx_cycle++;
        out_stall <= stall_next;
    end

    // Offer one byte and hold it until the block takes it. A new burst may
    // start with a random gap, during which valid drops.
    task automatic send_byte(input logic [7:0] b, input logic [vpcs_pkg::PLANE_W-1:0] p,
                             input logic closes);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        sample    <= b;
        plane     <= p;
        frame_end <= closes;
        do
            @(posedge clk);
        while (in_stall);
        board.note_byte(b, p, closes);
        burst_left--;
    endtask

    // Pause the sender until every queued report has come back and the
    // block has had time to clear its frame state.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_plane_count(input logic [vpcs_pkg::CFG_W-1:0] value);
        wait_drained();
        cfg_valid   <= 1'b1;
        plane_count <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_plane_count(value);
    endtask

    function automatic logic [7:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return 8'd0;
        if (roll < 4)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one frame and report how many bytes it held. Most frames carry
    // ascending plane tags; the rest tag each byte with a random plane.
    task automatic send_random_frame(output int sent);
        int                           len;
        logic                         scrambled;
        logic [vpcs_pkg::PLANE_W-1:0] p;
        len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
        scrambled = ($urandom_range(0, 4) == 0);
        p = vpcs_pkg::PLANE_W'($urandom_range(0, 1));
        for (int i = 0; i < len; i++)
        begin
            if (scrambled)
                p = vpcs_pkg::PLANE_W'($urandom_range(0, vpcs_pkg::PLANES - 1));
            else if (i != 0 && p != vpcs_pkg::PLANES - 1 && $urandom_range(0, 3) == 0)
                p = p + 2'd1;
            send_byte(pick_sample(), p, i == len - 1);
        end
        sent = len;
    endtask

    // Run one plane long enough that the high checksum half wraps.
    task automatic send_long_frame();
        for (int i = 0; i < 3; i++)
            send_byte(pick_sample(), 2'd0, 1'b0);
        for (int i = 0; i < 40; i++)
            send_byte(8'(255 - $urandom_range(0, 3)), 2'd1, 1'b0);
        send_byte(pick_sample(), 2'd3, 1'b1);
    endtask

    // Reported plane counts for the random phases, covering every value.
    logic [vpcs_pkg::CFG_W-1:0] phase_counts [8] =
        '{3'd2, 3'd3, 3'd5, 3'd6, 3'd4, 3'd1, 3'd7, 3'd0};

    initial
    begin
        int sent;
        int frame_bytes;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames, gapless, starting with the reset plane count.
        gap_max = 0;
        send_byte(8'd255, 2'd0, 1'b1);       // single-byte frame
        send_byte(8'd7, 2'd2, 1'b0);         // unreported plane ahead of plane 0
        send_byte(8'd0, 2'd0, 1'b1);

        write_plane_count(3'd4);
        send_byte(8'd0, 2'd0, 1'b0);         // plane 2 stays empty: mean of zero bytes
        send_byte(8'd255, 2'd0, 1'b0);
        send_byte(8'd128, 2'd1, 1'b0);
        send_byte(8'd1, 2'd3, 1'b0);
        send_byte(8'd254, 2'd3, 1'b0);
        send_byte(8'd255, 2'd3, 1'b1);
        send_byte(8'd10, 2'd3, 1'b0);        // planes out of order
        send_byte(8'd20, 2'd1, 1'b0);
        send_byte(8'd30, 2'd0, 1'b0);
        send_byte(8'd40, 2'd2, 1'b1);
        for (int i = 0; i < 4; i++)          // all-255 plane: mean at its top
            send_byte(8'd255, 2'd1, i == 3);

        write_plane_count(3'd0);             // zero reports a single plane
        send_byte(8'd1, 2'd0, 1'b0);
        send_byte(8'd2, 2'd0, 1'b0);
        send_byte(8'd9, 2'd3, 1'b1);

        write_plane_count(3'd7);             // above range reports four planes
        send_byte(8'd100, 2'd2, 1'b1);

        // Random phases, one per plane count setting.
        foreach (phase_counts[i])
        begin
            write_plane_count(phase_counts[i]);
            gap_max = (i % 3 == 0) ? 0 : 6;
            burst_left = 0;
            if (phase_counts[i] == 3'd4)
                hold_request <= 1'b1;
            if (i == 3)
                send_long_frame();
            sent = 0;
            while (sent < 12)
            begin
                send_random_frame(frame_bytes);
                sent += frame_bytes;
            end
        end

        wait_drained();
        if (board.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
